>>> design/s2a_pkg.sv
// Shared types, constants and lookup tables for the scancode-to-ASCII FIFO.
// No dependencies; imported by the interfaces, the top level, s2a_ctrl and s2a_dp.
package s2a_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_BREAK = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        SP_PUSH,
        SP_SHIFT_ON,
        SP_SHIFT_OFF,
        SP_CAPS,
        SP_CTRL_ON,
        SP_CTRL_OFF
    } t_sp_act;

    typedef struct packed {
        logic    hit;
        t_sp_act act;
        logic [7:0] code_byte;
    } t_sp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_RD_SETUP,
        ST_RD_EMPTY,
        ST_RD_ADDR,
        ST_RD_DATA
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic key_exec;
        logic rd_setup;
        logic rd_issue;
        logic out_break;
        logic out_empty;
        logic out_data;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_read;
        logic key_break;
        logic count_zero;
        logic fifo_empty;
        logic remain_zero;
        logic slot_free;
    } t_sts;

    localparam logic [7:0] ASCII_C = 8'h63;
    localparam logic [7:0] ASCII_A = 8'h61;
    localparam logic [7:0] ASCII_Z = 8'h7A;

    localparam logic [7:0] PLAIN_MAP [128] = '{
        8'h00, 8'hF1, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'hEF, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'hF2, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'hEC, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hEC, 8'h2A,
        8'hF4, 8'h20, 8'hEE, 8'hF5, 8'hF6, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hF7, 8'h00, 8'h2D, 8'hF8, 8'h00, 8'hF9, 8'h2B, 8'h00,
        8'hFA, 8'h00, 8'hFB, 8'hFC, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] UPPER_MAP [128] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'hF2, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'hEC, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Special scancodes; pushed bytes are the signed key codes.
    function automatic t_sp sp_lookup(input logic [7:0] code);
        t_sp r;
        r = '{hit: 1'b1, act: SP_PUSH, code_byte: 8'h00};
        unique case (code)
            8'd14:   r.code_byte = 8'hEF;
            8'd29:   r.act = SP_CTRL_ON;
            8'd42:   r.act = SP_SHIFT_ON;
            8'd54:   r.act = SP_SHIFT_ON;
            8'd56:   r.code_byte = 8'hF4;
            8'd58:   r.act = SP_CAPS;
            8'd59:   r.code_byte = 8'hF5;
            8'd60:   r.code_byte = 8'hF6;
            8'd72:   r.code_byte = 8'hF7;
            8'd75:   r.code_byte = 8'hF8;
            8'd77:   r.code_byte = 8'hF9;
            8'd80:   r.code_byte = 8'hFA;
            8'd157:  r.act = SP_CTRL_OFF;
            8'd170:  r.act = SP_SHIFT_OFF;
            8'd182:  r.act = SP_SHIFT_OFF;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> design/s2a_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on s2a_pkg.
interface s2a_in_if
    import s2a_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] scan_code;
    logic [6:0] read_count;

    modport source (output valid, op, scan_code, read_count, input ready);
    modport sink   (input valid, op, scan_code, read_count, output ready);
endinterface

interface s2a_out_if
    import s2a_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_byte;
    logic       is_last;

    modport source (output valid, kind, char_byte, is_last, input ready);
    modport sink   (input valid, kind, char_byte, is_last, output ready);
endinterface

>>> design/scancode_to_ascii_fifo_core.sv
// Set-1 scancode decoder with a character FIFO: top level.
// Depends on s2a_pkg, the channel interfaces, s2a_ctrl and s2a_dp.
//
// Usage:
//   i_in carries items: op 0 is a scancode event (scan_code), op 1 a read
//   request that pops up to read_count bytes (capped at MAX_READ).
//   o_out carries results: kind, char_byte, is_last (set on the last result
//   of an item). A scancode gives no result except the control-c break; a
//   read of an empty FIFO gives one empty result; a read of zero gives none.
// Sequencing:
//   one item at a time. A scancode item is accepted, then decoded and pushed.
//   A read popping n bytes is accepted, decoded and set up, then for each
//   byte the store RAM is addressed and its data registered for the result.
//   A break follows decode; a read of zero ends at setup, an empty read after.
// Reset clears the flags, the FIFO pointers and fill level, and the result
//   valid flag; the store contents are not cleared.
// A stalled receiver holds the single result register; the block keeps
//   working until it needs that register again, then waits.
module scancode_to_ascii_fifo_core
    import s2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 128,
    parameter int MAX_READ   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s2a_in_if.sink    i_in,
    s2a_out_if.source o_out
);
    t_cmd cmd;
    t_sts sts;

    s2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    s2a_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

>>> design/s2a_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module s2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/s2a_ctrl.sv
// Controller state machine: sequences key decode and FIFO reads.
// Depends on s2a_pkg; drives the datapath through t_cmd, watches t_sts.
module s2a_ctrl
    import s2a_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                if (i_sts.is_read) begin
                    n_state = ST_RD_SETUP;
                end else if (i_sts.key_break) begin
                    if (i_sts.slot_free) begin
                        o_cmd.out_break = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.key_exec = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RD_SETUP: begin
                o_cmd.rd_setup = 1'b1;
                priority if (i_sts.count_zero) begin
                    n_state = ST_IDLE;
                end else if (i_sts.fifo_empty) begin
                    n_state = ST_RD_EMPTY;
                end else begin
                    n_state = ST_RD_ADDR;
                end
            end
            ST_RD_EMPTY: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_empty = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_data = 1'b1;
                    n_state = i_sts.remain_zero ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> design/s2a_dp.sv
// Datapath: input latch, key decode, modifier flags, FIFO pointers and storage,
// result register. Depends on s2a_pkg, s2a_ram and the channel interfaces.
module s2a_dp
    import s2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 128,
    parameter int MAX_READ   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s2a_in_if.sink     i_in,
    s2a_out_if.source  o_out,
    input  t_cmd       i_cmd,
    output t_sts       o_sts
);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int CW = (FW > 7) ? FW : 7;

    logic          r_op;
    logic [7:0]    r_code;
    logic [6:0]    r_count;
    logic          r_shift, r_caps, r_ctrl;
    logic [AW-1:0] r_rd_ptr, r_wr_ptr;
    logic [FW-1:0] r_fill;
    logic [RW-1:0] r_remain;
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    t_sp        sp;
    logic [7:0] base, upper_ch, push_byte;
    logic       in_map, brk, letter, upper, push, full;
    logic [6:0] sat_cnt;
    logic [CW-1:0] take_n;
    logic [7:0] rd_data;
    logic       wr_en;

    // key decode
    always_comb begin
        sp       = sp_lookup(r_code);
        base     = PLAIN_MAP[r_code[6:0]];
        upper_ch = UPPER_MAP[r_code[6:0]];
        in_map   = (r_code != 8'd0) && !r_code[7];
        brk      = r_ctrl && (base == ASCII_C);
        letter   = (base >= ASCII_A) && (base <= ASCII_Z);
        upper    = letter ? (r_shift ^ r_caps) : r_shift;
        if (sp.hit) begin
            push      = (sp.act == SP_PUSH);
            push_byte = sp.code_byte;
        end else begin
            push      = in_map && !brk;
            push_byte = upper ? upper_ch : base;
        end
    end

    assign full    = (r_fill == FW'(FIFO_DEPTH));
    assign wr_en   = i_cmd.key_exec && push && !full;
    assign sat_cnt = (r_count > 7'(MAX_READ)) ? 7'(MAX_READ) : r_count;
    assign take_n  = (CW'(sat_cnt) < CW'(r_fill)) ? CW'(sat_cnt) : CW'(r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_in.op;
            r_code  <= i_in.scan_code;
            r_count <= i_in.read_count;
        end
        if (i_cmd.rd_setup) begin
            r_remain <= RW'(take_n);
        end else if (i_cmd.rd_issue) begin
            r_remain <= r_remain - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_ctrl   <= 1'b0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_cmd.key_exec && sp.hit) begin
                unique case (sp.act)
                    SP_SHIFT_ON:  r_shift <= 1'b1;
                    SP_SHIFT_OFF: r_shift <= 1'b0;
                    SP_CAPS:      r_caps  <= !r_caps;
                    SP_CTRL_ON:   r_ctrl  <= 1'b1;
                    SP_CTRL_OFF:  r_ctrl  <= 1'b0;
                    default:      ;
                endcase
            end
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
                r_fill   <= r_fill + FW'(1);
            end else if (i_cmd.rd_issue) begin
                r_rd_ptr <= (r_rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
                r_fill   <= r_fill - FW'(1);
            end
        end
    end

    s2a_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (push_byte),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    // result register; frees itself when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_break || i_cmd.out_empty || i_cmd.out_data) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.out_break) begin
            r_out_kind <= KIND_BREAK;
            r_out_byte <= 8'h00;
            r_out_last <= 1'b1;
        end else if (i_cmd.out_empty) begin
            r_out_kind <= KIND_EMPTY;
            r_out_byte <= 8'h00;
            r_out_last <= 1'b1;
        end else if (i_cmd.out_data) begin
            r_out_kind <= KIND_CHAR;
            r_out_byte <= rd_data;
            r_out_last <= (r_remain == '0);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out_kind;
    assign o_out.char_byte = r_out_byte;
    assign o_out.is_last   = r_out_last;

    assign o_sts.is_read     = (r_op == OP_READ);
    assign o_sts.key_break   = !sp.hit && in_map && brk;
    assign o_sts.count_zero  = (r_count == 7'd0);
    assign o_sts.fifo_empty  = (r_fill == '0);
    assign o_sts.remain_zero = (r_remain == '0);
    assign o_sts.slot_free   = !r_out_valid || o_out.ready;
endmodule

>>> tb/tb_scancode_to_ascii_fifo_core.sv
// Testbench for scancode_to_ascii_fifo_core: keystroke and read items with random content
// and random idling; every result is checked against a scoreboard with its own decoder.
// Depends on s2a_pkg, the s2a channel interfaces and the block's RTL.
module tb_scancode_to_ascii_fifo_core;
    import s2a_pkg::*;

    localparam int FIFO_DEPTH     = 128;
    localparam int MAX_READ       = 64;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 150;
    // longest correct silence is the long receiver hold; allow several times that
    localparam int WATCHDOG_LIMIT = 2000;

    // set-1 scancodes with special handling
    localparam logic [7:0] SC_BKSP      = 8'd14;
    localparam logic [7:0] SC_LCTRL     = 8'd29;
    localparam logic [7:0] SC_LSHIFT    = 8'd42;
    localparam logic [7:0] SC_RSHIFT    = 8'd54;
    localparam logic [7:0] SC_ALT       = 8'd56;
    localparam logic [7:0] SC_CAPS      = 8'd58;
    localparam logic [7:0] SC_F1        = 8'd59;
    localparam logic [7:0] SC_F2        = 8'd60;
    localparam logic [7:0] SC_UP        = 8'd72;
    localparam logic [7:0] SC_LEFT      = 8'd75;
    localparam logic [7:0] SC_RIGHT     = 8'd77;
    localparam logic [7:0] SC_DOWN      = 8'd80;
    localparam logic [7:0] SC_LCTRL_UP  = 8'd157;
    localparam logic [7:0] SC_LSHIFT_UP = 8'd170;
    localparam logic [7:0] SC_RSHIFT_UP = 8'd182;
    // ordinary keys and range-edge codes used by name
    localparam logic [7:0] SC_KEY_1     = 8'd2;
    localparam logic [7:0] SC_KEY_Q     = 8'd16;
    localparam logic [7:0] SC_KEY_C     = 8'd46;
    localparam logic [7:0] SC_TOP       = 8'd127;
    localparam logic [7:0] SC_MAX       = 8'd255;

    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_C = 8'h63;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

    localparam logic [7:0] MODIFIER_KEYS [6] = '{
        SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_UP, SC_RSHIFT_UP, SC_LCTRL, SC_LCTRL_UP
    };

    localparam logic [0:127][7:0] LOWER_KEYS = {
        128'h00F1313233343536_373839302D3DEF09,
        128'h7177657274797569_6F705B5D0AF26173,
        128'h646667686A6B6C3B_2760EC5C7A786376,
        128'h626E6D2C2E2FEC2A_F420EEF5F6000000,
        128'h0000000000000000_F7002DF800F92B00,
        128'hFA00FBFC00000000_0000000000000000,
        256'h0
    };

    localparam logic [0:127][7:0] UPPER_KEYS = {
        128'h001B21402324255E_262A28295F2B0800,
        128'h5157455254595549_4F507B7D0DF24153,
        128'h444647484A4B4C3A_227EEC7C5A584356,
        128'h424E4D3C3E3F002A_0020000000000000,
        128'h0000000000000000_00002D0000002B00,
        384'h0
    };

    typedef struct {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
    } key_result_t;

    class key_fifo_scoreboard;
        logic [7:0]  char_mem [FIFO_DEPTH];
        int unsigned head_idx;
        int unsigned fill_cnt;
        bit          shift_on;
        bit          caps_lock;
        bit          ctrl_on;
        key_result_t result_q [$];
        int unsigned mismatches;
        int unsigned items_seen;
        int unsigned results_seen;
        int unsigned empties;
        int unsigned breaks;
        int unsigned dropped;

        function int unsigned outstanding();
            return result_q.size();
        endfunction

        function void queue_result(t_kind kind, logic [7:0] ch, logic last);
            key_result_t r;
            r.kind = kind;
            r.ch   = ch;
            r.last = last;
            result_q.push_back(r);
        endfunction

        function void push_byte(logic [7:0] b);
            if (fill_cnt >= FIFO_DEPTH) begin
                dropped++;
                return;
            end
            char_mem[(head_idx + fill_cnt) % FIFO_DEPTH] = b;
            fill_cnt++;
        endfunction

        function void note_item(t_op op, logic [7:0] code, logic [6:0] cnt);
            logic [7:0]  base;
            bit          upper;
            int unsigned n;
            items_seen++;
            if (op == OP_SCAN) begin
                case (code)
                    SC_BKSP:                    push_byte(8'hEF);
                    SC_ALT:                     push_byte(8'hF4);
                    SC_F1:                      push_byte(8'hF5);
                    SC_F2:                      push_byte(8'hF6);
                    SC_UP:                      push_byte(8'hF7);
                    SC_LEFT:                    push_byte(8'hF8);
                    SC_RIGHT:                   push_byte(8'hF9);
                    SC_DOWN:                    push_byte(8'hFA);
                    SC_LCTRL:                   ctrl_on = 1'b1;
                    SC_LCTRL_UP:                ctrl_on = 1'b0;
                    SC_LSHIFT, SC_RSHIFT:       shift_on = 1'b1;
                    SC_LSHIFT_UP, SC_RSHIFT_UP: shift_on = 1'b0;
                    SC_CAPS:                    caps_lock = !caps_lock;
                    default: begin
                        if (code != 8'd0 && code < 8'd128) begin
                            base = LOWER_KEYS[code[6:0]];
                            if (ctrl_on && base == CHR_LOWER_C) begin
                                queue_result(KIND_BREAK, 8'h00, 1'b1);
                                breaks++;
                            end else begin
                                // caps lock only affects letters
                                if (base >= CHR_LOWER_A && base <= CHR_LOWER_Z)
                                    upper = shift_on ^ caps_lock;
                                else
                                    upper = shift_on;
                                push_byte(upper ? UPPER_KEYS[code[6:0]] : base);
                            end
                        end
                    end
                endcase
                return;
            end
            if (cnt == 0)
                return;
            n = (cnt > MAX_READ) ? MAX_READ : cnt;
            if (fill_cnt == 0) begin
                queue_result(KIND_EMPTY, 8'h00, 1'b1);
                empties++;
                return;
            end
            if (n > fill_cnt)
                n = fill_cnt;
            for (int unsigned k = 0; k < n; k++)
                queue_result(KIND_CHAR, char_mem[(head_idx + k) % FIFO_DEPTH], k + 1 == n);
            head_idx = (head_idx + n) % FIFO_DEPTH;
            fill_cnt -= n;
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] ch, logic last);
            key_result_t want;
            results_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d byte=%02h last=%0d", kind, ch, last);
                return;
            end
            want = result_q.pop_front();
            if (kind !== want.kind || ch !== want.ch || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch at %0t: kind %0d/%0d byte %02h/%02h last %0d/%0d",
                             $realtime, want.kind, kind, want.ch, ch, want.last, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    s2a_in_if  in_ch ();
    s2a_out_if out_ch ();

    key_fifo_scoreboard book = new();
    int unsigned        idle_pct;
    bit                 hold_request;
    int unsigned        quiet_cycles;

    scancode_to_ascii_fifo_core #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .MAX_READ  (MAX_READ)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                book.note_item(t_op'(in_ch.op), in_ch.scan_code, in_ch.read_count);
            if (out_ch.valid && out_ch.ready)
                book.check_result(out_ch.kind, out_ch.char_byte, out_ch.is_last);
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_pct != 0 && $urandom_range(0, 499) < idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_scancode_to_ascii_fifo_core failed");
        $finish;
    end

    task automatic drive_item(input t_op op, input logic [7:0] code, input logic [6:0] cnt);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.scan_code  <= code;
        in_ch.read_count <= cnt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic press(input logic [7:0] code);
        drive_item(OP_SCAN, code, 7'($urandom_range(0, 127)));
    endtask

    task automatic read_chars(input logic [6:0] cnt);
        drive_item(OP_READ, 8'($urandom_range(0, 255)), cnt);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (book.outstanding() != 0);
    endtask

    // mostly typing with modifiers and small reads, some noise and large reads
    task automatic random_item();
        int unsigned pick;
        logic [7:0]  code;
        logic [6:0]  cnt;
        pick = $urandom_range(0, 99);
        cnt  = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0)
            code = 8'($urandom_range(1, 127));
        else
            code = 8'($urandom_range(1, 83));
        if (pick < 12)
            code = MODIFIER_KEYS[$urandom_range(0, 5)];
        else if (pick < 15)
            code = SC_CAPS;
        else if (pick < 22)
            code = SC_KEY_C;
        else if (pick < 27)
            code = 8'($urandom_range(0, 255));
        if (pick < 80) begin
            drive_item(OP_SCAN, code, cnt);
        end else begin
            if (pick < 96)
                cnt = 7'($urandom_range(1, 4));
            drive_item(OP_READ, code, cnt);
        end
    endtask

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_SCAN;
        in_ch.scan_code  <= '0;
        in_ch.read_count <= '0;
        i_rst_n          <= 1'b0;
        idle_pct     = 0;
        hold_request = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty read, zero read, ignored codes, top of the table
        read_chars(7'd5);
        read_chars(7'd0);
        press(8'd0);
        press(SC_MAX);
        press(SC_TOP);
        // shift on a letter and a digit, right shift key
        press(SC_RSHIFT);
        press(SC_KEY_Q);
        press(SC_KEY_1);
        press(SC_RSHIFT_UP);
        // caps lock alone, then with shift
        press(SC_CAPS);
        press(SC_KEY_Q);
        press(SC_LSHIFT);
        press(SC_KEY_Q);
        press(SC_LSHIFT_UP);
        // keys that push their own code
        press(SC_BKSP);
        press(SC_ALT);
        press(SC_F1);
        press(SC_F2);
        press(SC_UP);
        press(SC_LEFT);
        press(SC_RIGHT);
        press(SC_DOWN);
        // control-c break, then control released
        press(SC_LCTRL);
        press(SC_KEY_C);
        press(SC_LCTRL_UP);
        // count above the read cap
        read_chars(7'd127);

        for (int i = 0; i < 165; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            random_item();
        end

        // overfill the store, then read it back behind a long receiver hold
        wait_drained();
        idle_pct = 10;
        press(SC_LCTRL_UP);
        repeat (140) press(8'($urandom_range(16, 25)));
        hold_request = 1'b1;
        read_chars(7'd64);
        read_chars(7'd64);
        repeat (6) press(8'($urandom_range(30, 38)));
        read_chars(7'd127);
        read_chars(7'd3);
        wait_drained();

        idle_pct = 0;
        repeat (120) random_item();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items and checked %0d results: %0d empty reads, %0d breaks,",
                 book.items_seen, book.results_seen, book.empties, book.breaks);
        $display("%0d bytes dropped by a full store, %0d mismatches",
                 book.dropped, book.mismatches);
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("tb_scancode_to_ascii_fifo_core passed");
        end else begin
            if (book.outstanding() != 0)
                $display("%0d expected results never arrived", book.outstanding());
            $display("tb_scancode_to_ascii_fifo_core failed");
        end
        $finish;
    end

endmodule
